FILE: hw/rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared widths and codes of the pool slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int POOL_ENTRIES = 512;

  localparam int SLOT_W   = 9;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

endpackage

FILE: hw/rtl/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pool_slot_allocator.sv
// ----------------------------------------------------------------------------
// pool_slot_allocator
// Fixed pool of slots: singly linked free list, doubly linked used list in
// allocation order. Allocate pops the free head, free unlinks a used slot.
//
//   channel   handshake           payload
//   request   start / busy        func, index
//   result    done (one cycle)    status, slot, slot_valid, used_count
//
// A transaction reads both link RAMs, patches neighbor links, then writes the
// slot's own entry; a rejected request ends after the reads and writes nothing.
// The next start may be taken in the cycle that done is high. The split into
// patch and write steps is set by the single write port of each link RAM.
// Reset is synchronous; a high-water mark stands in for the initial link
// chain, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module pool_slot_allocator
  import psa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [SLOT_W-1:0]   index,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic                slot_valid,
  output logic [COUNT_W-1:0]  used_count
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_LINK, ST_FINISH} state_t;

  state_t        state;
  logic          func_q;
  logic          bad_q;
  logic [LW-1:0] cur;
  logic [LW-1:0] prv;
  logic [LW-1:0] free_head;
  logic [LW-1:0] newest;
  logic [LW-1:0] used_total;
  logic [LW-1:0] hw;

  logic          accept;
  logic          re;
  logic [AW-1:0] a_raddr;
  logic [AW-1:0] b_raddr;
  logic [LW-1:0] a_rdata;
  logic [LW:0]   b_rdata;
  logic          a_we;
  logic [AW-1:0] a_waddr;
  logic [LW-1:0] a_wdata;
  logic          b_we;
  logic [AW-1:0] b_waddr;
  logic [LW:0]   b_wdata;

  logic          fresh;
  logic [LW-1:0] rd_next;
  logic [LW-1:0] rd_prev;
  logic          rd_in_use;
  logic          alloc_full;
  logic          free_bad;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign re     = accept;

  // next_link in RAM A, {in_use, prev_link} in RAM B
  assign a_raddr = (func == FUNC_FREE) ? AW'(index) : AW'(free_head);
  assign b_raddr = AW'(index);

  psa_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  psa_ram #(.WIDTH(LW + 1), .DEPTH(POOL_ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // entries at or above the high-water mark are never written; fresh link values stand in
  assign fresh      = (cur >= hw);
  assign rd_next    = fresh ? cur + LW'(1) : a_rdata;
  assign rd_prev    = fresh ? NIL : b_rdata[LW-1:0];
  assign rd_in_use  = fresh ? 1'b0 : b_rdata[LW];
  assign alloc_full = (used_total >= NIL) || (cur == NIL);
  assign free_bad   = bad_q || !rd_in_use;

  always_comb begin
    a_we    = 1'b0;
    a_waddr = AW'(cur);
    a_wdata = NIL;
    b_we    = 1'b0;
    b_waddr = AW'(cur);
    b_wdata = {1'b0, NIL};
    unique case (state)
      ST_IDLE: begin
      end
      ST_LINK: begin
        if (func_q == FUNC_ALLOC) begin
          a_we    = !alloc_full && (newest != NIL);
          a_waddr = AW'(newest);
          a_wdata = cur;
        end else begin
          a_we    = !free_bad && (rd_prev != NIL);
          a_waddr = AW'(rd_prev);
          a_wdata = rd_next;
          b_we    = !free_bad && (rd_next != NIL);
          b_waddr = AW'(rd_next);
          b_wdata = {1'b1, rd_prev};
        end
      end
      ST_FINISH: begin
        a_we = 1'b1;
        b_we = 1'b1;
        if (func_q == FUNC_ALLOC) begin
          a_wdata = NIL;
          b_wdata = {1'b1, newest};
        end else begin
          a_wdata = free_head;
          b_wdata = {1'b0, NIL};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      free_head  <= '0;
      newest     <= NIL;
      used_total <= '0;
      hw         <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            func_q <= func;
            bad_q  <= (func == FUNC_FREE) && (32'(index) >= POOL_ENTRIES);
            cur    <= (func == FUNC_FREE) ? LW'(index) : free_head;
            state  <= ST_LINK;
          end
        end
        ST_LINK: begin
          if (func_q == FUNC_ALLOC) begin
            if (alloc_full) begin
              done       <= 1'b1;
              status     <= STAT_FULL;
              slot       <= '0;
              slot_valid <= 1'b0;
              used_count <= COUNT_W'(used_total);
              state      <= ST_IDLE;
            end else begin
              free_head <= rd_next;
              state     <= ST_FINISH;
            end
          end else begin
            if (free_bad) begin
              done       <= 1'b1;
              status     <= STAT_NOT_USED;
              slot       <= '0;
              slot_valid <= 1'b0;
              used_count <= COUNT_W'(used_total);
              state      <= ST_IDLE;
            end else begin
              prv <= rd_prev;
              if (rd_next == NIL) begin
                newest <= rd_prev;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          done   <= 1'b1;
          status <= STAT_OK;
          state  <= ST_IDLE;
          if (func_q == FUNC_ALLOC) begin
            newest     <= cur;
            used_total <= used_total + LW'(1);
            if (cur >= hw) begin
              hw <= hw + LW'(1);
            end
            slot       <= SLOT_W'(cur);
            slot_valid <= 1'b1;
            used_count <= COUNT_W'(used_total + LW'(1));
          end else begin
            free_head <= cur;
            if (used_total != '0) begin
              used_total <= used_total - LW'(1);
              used_count <= COUNT_W'(used_total - LW'(1));
            end else begin
              used_count <= COUNT_W'(used_total);
            end
            slot       <= (prv != NIL) ? SLOT_W'(prv) : '0;
            slot_valid <= (prv != NIL);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_LINK || $past(state) == ST_FINISH))
    else $error("result strobe without a transaction in progress");

  a_free_empty_iff_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((free_head == NIL) == (used_total == NIL)))
    else $error("free list state disagrees with used count");

  a_count_below_mark: assert property (@(posedge clk) disable iff (rst)
    (used_total <= hw) && (hw <= NIL))
    else $error("used count above high-water mark");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

FILE: tb/pool_slot_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pool_slot_allocator_tb
// Drives allocate and free requests through the start/busy handshake and checks
// every done strobe against an in-bench model of the free list and used list.
// Covers empty and full pool, oldest/middle/newest/only-slot frees, double
// frees and random indexes, with phases of random sender gaps.
// ----------------------------------------------------------------------------
module pool_slot_allocator_tb;
  import psa_pkg::*;

  localparam int POOL = POOL_ENTRIES;
  localparam logic [COUNT_W-1:0] NIL = COUNT_W'(POOL);

  typedef struct {
    logic              f;
    logic [SLOT_W-1:0] idx;
    int                gap_pct;
  } pool_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                slot_valid;
    logic [COUNT_W-1:0]  used_count;
  } pool_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                func;
  logic [SLOT_W-1:0]   index;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                slot_valid;
  logic [COUNT_W-1:0]  used_count;

  pool_req_t    req_q[$];
  pool_result_t result_q[$];
  pool_req_t    drv_req;
  logic         req_taken;
  int           errors;

  // model state
  logic [COUNT_W-1:0] nxt_slot [POOL];
  logic [COUNT_W-1:0] prv_slot [POOL];
  logic               slot_busy [POOL];
  logic [COUNT_W-1:0] free_top;
  logic [COUNT_W-1:0] tail_slot;
  logic [COUNT_W-1:0] live_count;

  // stimulus-side view of the pool, used only to pick sensible indexes
  int gen_free[$];
  int gen_used[$];

  pool_slot_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .index      (index),
    .done       (done),
    .status     (status),
    .slot       (slot),
    .slot_valid (slot_valid),
    .used_count (used_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic pool_result_t next_pool_result(logic f, logic [SLOT_W-1:0] idx);
    pool_result_t       r;
    logic [COUNT_W-1:0] s;
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] n;
    r.status     = STAT_OK;
    r.slot       = '0;
    r.slot_valid = 1'b0;
    if (f == FUNC_ALLOC) begin
      s = free_top;
      if (live_count >= COUNT_W'(POOL) || s >= NIL) begin
        r.status = STAT_FULL;
      end else begin
        free_top = nxt_slot[s[SLOT_W-1:0]];
        if (tail_slot != NIL) nxt_slot[tail_slot[SLOT_W-1:0]] = s;
        nxt_slot[s[SLOT_W-1:0]]  = NIL;
        prv_slot[s[SLOT_W-1:0]]  = tail_slot;
        slot_busy[s[SLOT_W-1:0]] = 1'b1;
        tail_slot  = s;
        live_count = live_count + 1'b1;
        r.slot       = s[SLOT_W-1:0];
        r.slot_valid = 1'b1;
      end
    end else if (!slot_busy[idx]) begin
      r.status = STAT_NOT_USED;
    end else begin
      p = prv_slot[idx];
      n = nxt_slot[idx];
      if (p != NIL) nxt_slot[p[SLOT_W-1:0]] = n;
      if (n != NIL) prv_slot[n[SLOT_W-1:0]] = p;
      else tail_slot = p;
      prv_slot[idx]  = NIL;
      nxt_slot[idx]  = free_top;
      slot_busy[idx] = 1'b0;
      free_top = {1'b0, idx};
      if (live_count != 0) live_count = live_count - 1'b1;
      if (p != NIL) begin
        r.slot       = p[SLOT_W-1:0];
        r.slot_valid = 1'b1;
      end
    end
    r.used_count = live_count;
    return r;
  endfunction

  // queue one request and track which slots it leaves in use
  task automatic add_request(logic f, int idx, int gap_pct);
    pool_req_t q;
    int        k;
    q.f       = f;
    q.idx     = idx[SLOT_W-1:0];
    q.gap_pct = gap_pct;
    req_q.push_back(q);
    if (f == FUNC_ALLOC) begin
      if (gen_free.size() != 0) gen_used.push_back(gen_free.pop_front());
    end else begin
      for (k = 0; k < gen_used.size(); k++) begin
        if (gen_used[k] == idx) begin
          gen_used.delete(k);
          gen_free.push_front(idx);
          break;
        end
      end
    end
  endtask

  // driver: present the next transaction once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_q.size() != 0 && $urandom_range(99, 0) >= req_q[0].gap_pct) begin
        drv_req = req_q.pop_front();
        start <= 1'b1;
        func  <= drv_req.f;
        index <= drv_req.idx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict for a transaction taken at this edge
  always @(posedge clk) begin
    pool_result_t e;
    if (!rst) begin
      if (done) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d valid=%0b count=%0d",
                   $time, status, slot, slot_valid, used_count);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (status !== e.status || slot !== e.slot || slot_valid !== e.slot_valid ||
              used_count !== e.used_count) begin
            $display("%0t: mismatch expected status=%0d slot=%0d valid=%0b count=%0d",
                     $time, e.status, e.slot, e.slot_valid, e.used_count);
            $display("%0t:          actual   status=%0d slot=%0d valid=%0b count=%0d",
                     $time, status, slot, slot_valid, used_count);
            errors++;
          end
        end
      end
      if (start && !busy) result_q.push_back(next_pool_result(func, index));
    end
    req_taken <= !rst && start && !busy;
  end

  initial begin
    #5_000_000;
    $display("pool_slot_allocator_tb NOT OK");
    $finish;
  end

  initial begin
    int alloc_pct [4];
    int gap_pct [4];
    int len [4];
    int i;
    int ph;
    int k;
    int r;
    rst       = 1'b1;
    start     = 1'b0;
    func      = FUNC_ALLOC;
    index     = '0;
    req_taken = 1'b0;
    errors    = 0;
    for (i = 0; i < POOL; i++) begin
      nxt_slot[i]  = COUNT_W'(i + 1);
      prv_slot[i]  = NIL;
      slot_busy[i] = 1'b0;
      gen_free.push_back(i);
    end
    free_top   = '0;
    tail_slot  = NIL;
    live_count = '0;

    // directed: empty pool, only slot, oldest/middle/newest, double free
    add_request(FUNC_FREE, 0, 0);
    add_request(FUNC_FREE, 511, 0);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_FREE, 0, 0);
    add_request(FUNC_ALLOC, 511, 0);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_ALLOC, 'h155, 0);
    add_request(FUNC_ALLOC, 'h0aa, 0);
    add_request(FUNC_FREE, 2, 0);
    add_request(FUNC_FREE, 0, 0);
    add_request(FUNC_FREE, 3, 0);
    add_request(FUNC_FREE, 3, 0);
    add_request(FUNC_FREE, 256, 0);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_ALLOC, 0, 0);
    add_request(FUNC_FREE, 1, 0);
    add_request(FUNC_FREE, 'h1ff, 0);
    add_request(FUNC_ALLOC, 0, 0);

    // random: mixed, fill past full, drain, mixed
    alloc_pct = '{60, 99, 25, 55};
    gap_pct   = '{0, 86, 12, 0};
    len       = '{420, 520, 480, 430};
    for (ph = 0; ph < 4; ph++) begin
      for (i = 0; i < len[ph]; i++) begin
        r = $urandom_range(99, 0);
        if (r < 3) begin
          add_request(FUNC_FREE, $urandom_range(511, 0), gap_pct[ph]);
        end else if (r < 6) begin
          // free of a slot that is already free
          add_request(FUNC_FREE, (gen_free.size() != 0) ? gen_free[0] : 0, gap_pct[ph]);
        end else if ($urandom_range(99, 0) < alloc_pct[ph] || gen_used.size() == 0) begin
          add_request(FUNC_ALLOC, $urandom_range(511, 0), gap_pct[ph]);
        end else begin
          k = $urandom_range(gen_used.size() - 1, 0);
          add_request(FUNC_FREE, gen_used[k], gap_pct[ph]);
        end
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || start || result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("pool_slot_allocator_tb OK");
    end else begin
      $display("pool_slot_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
